[hdl/dacfp_pkg.sv]
// Constants shared by the DAC/ADC command frame parser: frame markers, type codes and lengths.
// No dependencies.
package dacfp_pkg;

  localparam logic [7:0]  HDR_BYTE    = 8'h69;
  localparam logic [7:0]  TAIL_BYTE   = 8'h96;
  localparam logic [15:0] STALE_RESET = 16'd1000;

  // Frame type codes carried in the second byte of a frame.
  localparam logic [7:0] TYPE_DAC_REPORT = 8'd0;
  localparam logic [7:0] TYPE_DAC_ONLY   = 8'd1;
  localparam logic [7:0] TYPE_PERIOD     = 8'd2;

  // Frame lengths in bytes, header and tail included.
  localparam int unsigned LEN_DAC    = 7;
  localparam int unsigned LEN_PERIOD = 4;

  // Only the first seven bytes of a frame are ever looked at.
  localparam int unsigned FRAME_KEEP = 7;

  // Configuration register indexes.
  localparam logic REG_STALE_LIMIT = 1'b0;

endpackage

[hdl/dac_adc_command_frame_parser.sv]
// Top level of the DAC/ADC command frame parser: input stage, frame decode and result register.
// Depends on dacfp_pkg.
//
//  channel   | dir | handshake               | payload
//  ----------+-----+-------------------------+------------------------------------------------
//  s_axis    | in  | s_tvalid / s_tready     | tuser: op; tdata: rx_byte, adc_first, adc_second
//  m_axis    | out | m_tvalid / m_tready     | tuser: dac_valid, report_valid; tdata: dac and
//            |     |                         | report words
//  apb       | in  | psel/penable/pwrite     | stale_limit_ms at byte address 0
//
// A beat accepted from s_axis is held in the input register while the decode logic works
// on it, and its result is loaded into the result register when the beat moves on; it is
// taken from there. The decode is short: an increment, a subtract and a compare on the tick
// path, and a subtract, a compare and a small byte select on the byte path. A new beat can
// be accepted every cycle while the result side keeps up.
// Reset is synchronous; it clears the time counts, the frame byte count, the report period
// and both valid flags, and restores the stale limit to 1000 ms.
// When the result register is full and not taken, the input register holds its beat and
// s_tready falls, so stalls propagate back one beat at a time without loss.
module dac_adc_command_frame_parser #(
  parameter int unsigned MAX_FRAME_BYTES = 7
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [7:0] rx_byte, [19:8] adc_first, [31:20] adc_second
  input  logic [0:0]  s_tuser,   // [0] op: 0 received byte, 1 millisecond tick
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // [15:0] dac_first, [31:16] dac_second, [63:32] report_time,
                                 // [75:64] report_adc_first, [87:76] report_adc_second
  output logic [1:0]  m_tuser,   // [0] dac_valid, [1] report_valid
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dacfp_pkg::*;

  localparam int unsigned CW = $clog2(MAX_FRAME_BYTES + 1);

  // Configuration.
  logic [15:0] stale_limit_ms;

  // Parser state.
  logic [31:0] time_ms;
  logic [31:0] last_byte_time;
  logic [31:0] last_sample_time;
  logic [7:0]  sample_period;
  logic [CW-1:0] byte_count;
  logic [7:0]  frame_bytes [FRAME_KEEP];

  // Input register.
  logic        stg_valid;
  logic        stg_op;
  logic [7:0]  stg_byte;
  logic [11:0] stg_adc_first;
  logic [11:0] stg_adc_second;

  logic adv;

  // The staged beat moves on whenever the result register is free or being emptied.
  assign adv      = stg_valid && (!m_tvalid || m_tready);
  assign s_tready = !stg_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (s_tready) begin
      stg_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      stg_op         <= s_tuser[0];
      stg_byte       <= s_tdata[7:0];
      stg_adc_first  <= s_tdata[19:8];
      stg_adc_second <= s_tdata[31:20];
    end
  end

  // Configuration port: paddr[2] selects the register; the low two address bits are ignored.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_STALE_LIMIT) ? {16'd0, stale_limit_ms} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      stale_limit_ms <= STALE_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_STALE_LIMIT) begin
      stale_limit_ms <= pwdata[15:0];
    end
  end

  // Tick path: advance the clock and check whether a timed report is due.
  logic [31:0] time_inc;
  logic [31:0] since_sample;
  logic        report_due;

  assign time_inc     = time_ms + 32'd1;
  assign since_sample = time_inc - last_sample_time;
  assign report_due   = (sample_period != 8'd0) && (since_sample >= {24'd0, sample_period});

  // Byte path: drop a stale partial frame, wrap a full buffer, then store the byte.
  logic [31:0]   since_byte;
  logic          stale;
  logic [CW-1:0] cnt0;
  logic [CW-1:0] idx;
  logic [CW-1:0] cnt1;
  logic [7:0]    nb [FRAME_KEEP];
  logic [7:0]    ftype;
  logic          type_ok;
  logic [CW-1:0] flen;
  logic [7:0]    tail;
  logic          complete;
  logic          tail_ok;

  assign since_byte = time_ms - last_byte_time;
  assign stale      = since_byte > {16'd0, stale_limit_ms};
  assign cnt0       = stale ? '0 : byte_count;
  assign idx        = (cnt0 >= CW'(MAX_FRAME_BYTES)) ? '0 : cnt0;
  assign cnt1       = idx + CW'(1);

  // View of the buffer with the new byte already in place.
  always_comb begin
    for (int i = 0; i < FRAME_KEEP; i++) begin
      nb[i] = (idx == CW'(i)) ? stg_byte : frame_bytes[i];
    end
  end

  assign ftype    = nb[1];
  assign type_ok  = (ftype == TYPE_DAC_REPORT) || (ftype == TYPE_DAC_ONLY) ||
                    (ftype == TYPE_PERIOD);
  assign flen     = (ftype == TYPE_PERIOD) ? CW'(LEN_PERIOD) : CW'(LEN_DAC);
  assign tail     = (ftype == TYPE_PERIOD) ? nb[LEN_PERIOD-1] : nb[LEN_DAC-1];
  assign complete = (cnt1 >= CW'(2)) && type_ok && (cnt1 >= flen);
  assign tail_ok  = (tail == TAIL_BYTE);

  // Next state and result of the staged beat.
  logic [CW-1:0] byte_count_next;
  logic [7:0]    sample_period_next;
  logic          dac_emit;
  logic          rep_emit;

  always_comb begin
    byte_count_next    = byte_count;
    sample_period_next = sample_period;
    dac_emit           = 1'b0;
    rep_emit           = 1'b0;
    if (stg_op) begin
      rep_emit = report_due;
    end else if (nb[0] != HDR_BYTE) begin
      byte_count_next = '0;
    end else if (cnt1 >= CW'(2) && !type_ok) begin
      byte_count_next = '0;
    end else if (complete) begin
      byte_count_next = '0;
      if (tail_ok) begin
        case (ftype)
          TYPE_PERIOD: begin
            sample_period_next = nb[2];
          end
          TYPE_DAC_REPORT: begin
            dac_emit = 1'b1;
            rep_emit = 1'b1;
          end
          default: begin
            dac_emit = 1'b1;
          end
        endcase
      end
    end else begin
      byte_count_next = cnt1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_ms          <= 32'd0;
      last_byte_time   <= 32'd0;
      last_sample_time <= 32'd0;
      sample_period    <= 8'd0;
      byte_count       <= '0;
    end else if (adv) begin
      byte_count    <= byte_count_next;
      sample_period <= sample_period_next;
      if (stg_op) begin
        time_ms <= time_inc;
        if (report_due) begin
          last_sample_time <= time_inc;
        end
      end else begin
        last_byte_time <= time_ms;
      end
    end
  end

  // The frame buffer has no reset: every entry is written before it is read.
  always_ff @(posedge clk) begin
    if (adv && !stg_op) begin
      for (int i = 0; i < FRAME_KEEP; i++) begin
        if (idx == CW'(i)) begin
          frame_bytes[i] <= stg_byte;
        end
      end
    end
  end

  // Result register. The report time is the count after any tick of this beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= dac_emit || rep_emit;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (adv) begin
      m_tuser          <= {rep_emit, dac_emit};
      m_tdata[15:0]    <= dac_emit ? {nb[3], nb[2]} : 16'd0;
      m_tdata[31:16]   <= dac_emit ? {nb[5], nb[4]} : 16'd0;
      m_tdata[63:32]   <= rep_emit ? (stg_op ? time_inc : time_ms) : 32'd0;
      m_tdata[75:64]   <= rep_emit ? stg_adc_first : 12'd0;
      m_tdata[87:76]   <= rep_emit ? stg_adc_second : 12'd0;
    end
  end

`ifndef SYNTH
  // The byte count is always cleared on reaching a full frame.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count < CW'(FRAME_KEEP))
    else $error("byte count reached a full frame without being cleared");

  // A result in the output register always carries at least one valid flag.
  a_result_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser != 2'b00))
    else $error("result beat with neither dac_valid nor report_valid");

  // A tick advances the millisecond count by exactly one.
  a_tick_inc: assert property (@(posedge clk) disable iff (rst)
    (adv && stg_op) |=> (time_ms == $past(time_ms) + 32'd1))
    else $error("tick did not advance time_ms by one");

  // A byte records the current time as its arrival time.
  a_byte_time: assert property (@(posedge clk) disable iff (rst)
    (adv && !stg_op) |=> (last_byte_time == time_ms))
    else $error("byte arrival time not recorded");

  // A timed report never appears while auto-reporting is off.
  a_no_timed_report: assert property (@(posedge clk) disable iff (rst)
    (adv && stg_op && sample_period == 8'd0) |=> !m_tvalid)
    else $error("timed report with auto-reporting disabled");
`endif

endmodule

[sim/dacfp_tb_pkg.sv]
// Verification types for the DAC/ADC command frame parser: beat kinds and the result record.
// Depends on nothing; used by the checker and the testbench top.
`timescale 1ns / 1ps
package dacfp_tb_pkg;

  // Kind of an input beat, carried in s_tuser[0].
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic        dac_valid;
    logic        report_valid;
    logic [15:0] dac_first;
    logic [15:0] dac_second;
    logic [31:0] report_time;
    logic [11:0] adc_first;
    logic [11:0] adc_second;
  } parser_result_t;

endpackage

[sim/dacfp_checker.sv]
// Checker for the DAC/ADC command frame parser: follows both streams and the APB port,
// predicts every result beat and compares it field by field. Depends on both packages.
`timescale 1ns / 1ps
module dacfp_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic [0:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [87:0] m_tdata,
  input  logic [1:0]  m_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatches,
  output int          outstanding
);
  import dacfp_pkg::*;
  import dacfp_tb_pkg::*;

  // Shadow copy of the parser state.
  logic [15:0]  stale_limit;
  logic [31:0]  time_ms;
  logic [31:0]  last_byte_time;
  logic [31:0]  last_sample_time;
  logic [7:0]   sample_period;
  int unsigned  byte_count;
  logic [7:0]   frame_buf [0:FRAME_KEEP-1];

  parser_result_t due_results [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  task automatic note_mismatch(input string what);
    $display("%0t: mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      note_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  // Advances the shadow state by one accepted beat and queues the result it causes.
  task automatic parse_beat(input logic op, input logic [7:0] rx,
                            input logic [11:0] adc_a, input logic [11:0] adc_b);
    parser_result_t res;
    int unsigned    len;
    res = '0;
    if (op == OP_TICK) begin
      time_ms = time_ms + 32'd1;
      if (sample_period != 8'd0 && (time_ms - last_sample_time) >= 32'(sample_period)) begin
        last_sample_time = time_ms;
        res.report_valid = 1'b1;
        res.report_time  = time_ms;
        res.adc_first    = adc_a;
        res.adc_second   = adc_b;
        due_results.push_back(res);
      end
    end else begin
      if ((time_ms - last_byte_time) > stale_limit) byte_count = 0;
      last_byte_time = time_ms;
      if (byte_count >= FRAME_KEEP) byte_count = 0;
      frame_buf[byte_count] = rx;
      byte_count++;
      if (frame_buf[0] != HDR_BYTE) begin
        byte_count = 0;
      end else if (byte_count >= 2) begin
        if (frame_buf[1] > TYPE_PERIOD) begin
          byte_count = 0;
        end else begin
          len = (frame_buf[1] == TYPE_PERIOD) ? LEN_PERIOD : LEN_DAC;
          if (byte_count >= len) begin
            if (frame_buf[len-1] == TAIL_BYTE) begin
              if (frame_buf[1] == TYPE_PERIOD) begin
                sample_period = frame_buf[2];
              end else begin
                res.dac_valid  = 1'b1;
                res.dac_first  = {frame_buf[3], frame_buf[2]};
                res.dac_second = {frame_buf[5], frame_buf[4]};
                if (frame_buf[1] == TYPE_DAC_REPORT) begin
                  res.report_valid = 1'b1;
                  res.report_time  = time_ms;
                  res.adc_first    = adc_a;
                  res.adc_second   = adc_b;
                end
                due_results.push_back(res);
              end
            end
            byte_count = 0;
          end
        end
      end
    end
  endtask

  task automatic check_result(input parser_result_t got);
    parser_result_t want;
    if (due_results.size() == 0) begin
      note_mismatch($sformatf("result beat with nothing expected, tuser %b",
                              {got.report_valid, got.dac_valid}));
      return;
    end
    want = due_results.pop_front();
    compare_field("dac_valid", 32'(got.dac_valid), 32'(want.dac_valid));
    compare_field("report_valid", 32'(got.report_valid), 32'(want.report_valid));
    compare_field("dac_first", 32'(got.dac_first), 32'(want.dac_first));
    compare_field("dac_second", 32'(got.dac_second), 32'(want.dac_second));
    compare_field("report_time", got.report_time, want.report_time);
    compare_field("report_adc_first", 32'(got.adc_first), 32'(want.adc_first));
    compare_field("report_adc_second", 32'(got.adc_second), 32'(want.adc_second));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      stale_limit      = STALE_RESET;
      time_ms          = '0;
      last_byte_time   = '0;
      last_sample_time = '0;
      sample_period    = '0;
      byte_count       = 0;
      due_results.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == {REG_STALE_LIMIT, 2'b00})
        stale_limit = pwdata[15:0];
      // Results are checked before the new beat is predicted: a beat accepted at this
      // edge cannot already have its result on the output.
      if (m_tvalid && m_tready)
        check_result('{dac_valid: m_tuser[0], report_valid: m_tuser[1],
                       dac_first: m_tdata[15:0], dac_second: m_tdata[31:16],
                       report_time: m_tdata[63:32], adc_first: m_tdata[75:64],
                       adc_second: m_tdata[87:76]});
      if (s_tvalid && s_tready)
        parse_beat(s_tuser[0], s_tdata[7:0], s_tdata[19:8], s_tdata[31:20]);
    end
    outstanding = due_results.size();
  end

endmodule

[sim/tb.sv]
// Testbench top for the DAC/ADC command frame parser: clock, reset, byte and tick stimulus,
// APB writes of the stale limit and the verdict. Depends on the RTL, both packages and the checker.
`timescale 1ns / 1ps
module tb;
  import dacfp_pkg::*;
  import dacfp_tb_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [7:0] rx_byte, [19:8] adc_first, [31:20] adc_second
  logic [0:0]  s_tuser = '0;   // [0] op
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [87:0] m_tdata;        // [15:0] dac_first, [31:16] dac_second, [63:32] report_time,
                               // [75:64] report_adc_first, [87:76] report_adc_second
  logic [1:0]  m_tuser;        // [0] dac_valid, [1] report_valid
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int mismatches;
  int due_count;

  // Number of input beats accepted so far, and whether the sender is in a gap-free stretch.
  int beats_sent = 0;
  bit src_calm   = 1'b0;

  always #5 clk = ~clk;

  dac_adc_command_frame_parser dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  dacfp_checker chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .pready(pready), .mismatches(mismatches), .outstanding(due_count)
  );

  // Offers one beat after a random gap and returns at the edge where it is accepted.
  // Valid is only written once per time step: lowered for a gap, raised for the beat.
  task automatic offer_beat(input logic op, input logic [7:0] data,
                            input logic [11:0] adc_a, input logic [11:0] adc_b);
    int gap;
    gap = src_calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {adc_b, adc_a, data};
    do @(posedge clk); while (!s_tready);
    beats_sent++;
  endtask

  // One command from the host side. Most are well-formed frames with random contents;
  // some are corrupted in one byte and some are short runs of noise. Ticks are slipped in
  // between bytes now and then, which matters once the stale limit is small.
  task automatic send_command();
    logic [7:0] cmd [0:6];
    int         n;
    int         pick;
    int         k;
    pick = $urandom_range(0, 99);
    if (pick < 85) begin
      cmd[0] = HDR_BYTE;
      cmd[1] = (pick < 40) ? TYPE_DAC_REPORT : (pick < 70) ? TYPE_DAC_ONLY : TYPE_PERIOD;
      n = (cmd[1] == TYPE_PERIOD) ? LEN_PERIOD : LEN_DAC;
      for (k = 2; k < n - 1; k++) cmd[k] = 8'($urandom_range(0, 255));
      if (cmd[1] == TYPE_PERIOD) begin
        // Mostly short periods so that timed reports are frequent; off and longest too.
        case ($urandom_range(0, 9))
          0: cmd[2] = 8'd0;
          1: cmd[2] = 8'd255;
          2: cmd[2] = 8'($urandom_range(0, 255));
          default: cmd[2] = 8'($urandom_range(1, 8));
        endcase
      end
      cmd[n-1] = TAIL_BYTE;
      if ($urandom_range(0, 9) == 0)
        cmd[$urandom_range(0, n - 1)] = 8'($urandom_range(0, 255));
    end else begin
      n = $urandom_range(1, 3);
      for (k = 0; k < n; k++) cmd[k] = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 1) == 1) cmd[0] = HDR_BYTE;
    end
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 7) == 0)
        offer_beat(OP_TICK, 8'($urandom_range(0, 255)), 12'($urandom_range(0, 4095)),
                   12'($urandom_range(0, 4095)));
      offer_beat(OP_BYTE, cmd[k], 12'($urandom_range(0, 4095)),
                 12'($urandom_range(0, 4095)));
    end
  endtask

  // Stops offering beats and waits until every expected result has been taken, plus a settling
  // wait for beats that cause no result and may still sit in the two-stage pipeline.
  task automatic drain_results(input int settle);
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (due_count == 0);
    repeat (settle) @(posedge clk);
  endtask

  // APB write of the stale limit: setup cycle, then access cycle.
  task automatic set_stale_limit(input logic [15:0] ms);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {REG_STALE_LIMIT, 2'b00};
    pwdata  <= {16'h0000, ms};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Result side: random stalls with calm stretches, and twice a long hold-off so that the
  // result register stays full and the parser has to push back on its input.
  initial begin : result_sink
    int  stall;
    int  taken;
    bit  calm;
    taken = 0;
    calm  = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) calm = ~calm;
      stall = calm ? 0 : $urandom_range(0, 7);
      if (taken == 30 || taken == 400) stall = 150;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      taken++;
    end
  end

  initial begin : stimulus
    logic [7:0]  opening [0:24];
    logic [15:0] limits [0:3];
    int          k;
    int          phase;
    int          phase_start;
    // Wrong header, unknown type, a full type 0 frame with both DAC word extremes, a type 1
    // frame, a period frame with a bad tail (ignored), then a period of one millisecond.
    opening = '{8'h00,
                8'h69, 8'hFF,
                8'h69, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h96,
                8'h69, 8'h01, 8'h34, 8'h12, 8'h78, 8'h56, 8'h96,
                8'h69, 8'h02, 8'h05, 8'h00,
                8'h69, 8'h02, 8'h01, 8'h96};
    // Stale limits for the later phases; the first phase runs at the reset value.
    limits = '{16'd0, 16'hFFFF, 16'd3, 16'd0};
    limits[3] = 16'($urandom_range(1, 40));

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (k = 0; k < 25; k++)
      offer_beat(OP_BYTE, opening[k], k[0] ? 12'hFFF : 12'h000, k[0] ? 12'h000 : 12'hFFF);
    // With a period of one, the first tick must report.
    offer_beat(OP_TICK, 8'hA5, 12'h000, 12'hFFF);

    for (phase = 0; phase < 5; phase++) begin
      if (phase > 0) begin
        drain_results(6);
        set_stale_limit(limits[phase-1]);
      end
      phase_start = beats_sent;
      while (beats_sent - phase_start < 200) begin
        if ($urandom_range(0, 15) == 0) src_calm = ~src_calm;
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 12))
            offer_beat(OP_TICK, 8'($urandom_range(0, 255)), 12'($urandom_range(0, 4095)),
                       12'($urandom_range(0, 4095)));
        end else begin
          send_command();
        end
      end
    end

    drain_results(8);
    if (mismatches == 0 && due_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run of this stimulus.
  initial begin : watchdog
    #3_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
